### src/box_blur_3x3_stream_macros.svh
// ----------------------------------------------------------------------------
// box_blur_3x3_stream assertion macros
// Shared concurrent assertion shorthands for the blur pipeline.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_STREAM_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BB3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types and constants shared by the 3x3 box blur stream.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = 12;   // nine 8-bit pixels: max 2295
  localparam int MIN_DIM   = 3;

  // floor(s/9) == (s * 7282) >> 16 for every s <= 2295
  localparam int RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] blurred;
    logic             frame_last;
  } res_t;

  // one line store entry: rows y-2 and y-1 at the same column
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_t;

  // per-pixel position status carried down the pipe
  typedef struct packed {
    logic             emit;
    logic             interior;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_info_t;

endpackage

### src/bb3_if.sv
// ----------------------------------------------------------------------------
// bb3 stream interfaces
// Valid/ready channels for input pixels and blurred results.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
  import bb3_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bb3_res_if;
  import bb3_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/box_blur_3x3_stream.sv
// A pixel passes stage 1, then, if it has a result, the sum and output registers.
// Throughput: one pixel per clock unless the output or the clear sweep holds it;
// output stalls back up through two stages. Reset: config returns to 640x480,
// window and counters clear; then a sweep (one line-store entry per cycle) zeroes
// the line memory with pix_in.ready low. Config writes are taken during the sweep.
// ----------------------------------------------------------------------------
// box_blur_3x3_stream
// Streaming 3x3 box filter on 8-bit grey pixels with two line stores.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i,
  bb3_pix_if.sink                       pix_in,
  bb3_res_if.source                     res_out
);
  import bb3_pkg::*;

  // column counter covers the line store; WW also holds the width register
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // config registers
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;

  // raster position of the next pixel
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  // position of the pixel being offered
  logic [CW-1:0]    x;
  logic [ROW_W-1:0] y;
  logic [WW-1:0]    x_ext, w_ext, eff_w, cx_ext;
  logic [ROW_W-1:0] eff_h;
  logic             col_wrap, row_wrap;
  pos_info_t        info_d;

  // handshake / pipe control
  logic             accept;
  logic             clr_busy;
  logic             s1_go;
  logic             div_ready;

  // stage 1: pixel plus line store read data
  logic             s1_v_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [CW-1:0]    s1_idx_q;
  pos_info_t        s1_info_q;
  line_t            line_rd, line_wr;
  logic [SUM_W-1:0] win_sum;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to [3, MAX_WIDTH], height floored at 3
  always_comb begin
    w_ext = WW'(width_q);
    if (w_ext < WW'(MIN_DIM)) begin
      eff_w = WW'(MIN_DIM);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    eff_h = (height_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : height_q;
  end

  // ---------------------------------------------------------------------------
  // Position tracking: frame_start forces (0,0); wrap at the effective size
  // ---------------------------------------------------------------------------
  always_comb begin
    x        = pix_in.data.frame_start ? '0 : col_q;
    y        = pix_in.data.frame_start ? '0 : row_q;
    x_ext    = {{(WW-CW){1'b0}}, x};
    col_wrap = (x_ext + WW'(1)) >= eff_w;
    row_wrap = ({1'b0, y} + (ROW_W+1)'(1)) >= {1'b0, eff_h};
    col_d    = col_wrap ? '0 : CW'(x_ext + WW'(1));
    if (col_wrap) begin
      row_d = row_wrap ? '0 : y + ROW_W'(1);
    end else begin
      row_d = y;
    end

    // the result belongs to the center one row up and one column left
    cx_ext          = x_ext - WW'(1);
    info_d.emit     = (y != '0) && (x != '0);
    info_d.interior = (y > ROW_W'(1)) && (x > CW'(1));
    info_d.last     = (y == eff_h - ROW_W'(1)) && (x_ext == eff_w - WW'(1));
    info_d.row      = y - ROW_W'(1);
    info_d.col      = cx_ext[COL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe control. Stage 1 retires a pixel that emits nothing regardless of
  // the downstream stages, so border pixels never stall on a full output.
  // ---------------------------------------------------------------------------
  assign s1_go        = s1_v_q && (!s1_info_q.emit || div_ready);
  assign pix_in.ready = !clr_busy && (!s1_v_q || s1_go);
  assign accept       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (!s1_v_q || s1_go) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pix_in.data.pixel;
      s1_idx_q  <= x;
      s1_info_q <= info_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: read at transfer, write back (shift rows up) as stage 1 retires
  // ---------------------------------------------------------------------------
  assign line_wr = '{upper: line_rd.middle, middle: s1_px_q};

  bb3_line_store #(
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (x),
    .wr_en_i    (s1_go),
    .wr_idx_i   (s1_idx_q),
    .wr_data_i  (line_wr),
    .rd_data_o  (line_rd),
    .clr_busy_o (clr_busy)
  );

  // ---------------------------------------------------------------------------
  // Window and nine-pixel sum
  // ---------------------------------------------------------------------------
  bb3_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_go),
    .px_i   (s1_px_q),
    .line_i (line_rd),
    .sum_o  (win_sum)
  );

  // ---------------------------------------------------------------------------
  // Divide by nine and output register
  // ---------------------------------------------------------------------------
  bb3_div9_out u_div9_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_v_q && s1_info_q.emit),
    .in_ready_o (div_ready),
    .sum_i      (win_sum),
    .info_i     (s1_info_q),
    .res_out    (res_out)
  );

endmodule

### src/bb3_line_store.sv
// ----------------------------------------------------------------------------
// bb3_line_store
// Two-row line memory with post-reset clear sweep and write-to-read bypass.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_stream_macros.svh"

module bb3_line_store #(
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_idx_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_idx_i,
  input  bb3_pkg::line_t           wr_data_i,
  output bb3_pkg::line_t           rd_data_o,
  output logic                     clr_busy_o
);
  import bb3_pkg::*;

  localparam int AW = $clog2(Depth);

  line_t           mem [Depth];
  line_t           rdata_q;
  line_t           fwd_data_q;
  logic            fwd_q;
  logic            clr_busy_q;
  logic [AW-1:0]   clr_addr_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  line_t           mem_wdata;

  // clear sweep owns the write port until done
  always_comb begin
    mem_we    = clr_busy_q | wr_en_i;
    mem_waddr = clr_busy_q ? clr_addr_q : wr_idx_i;
    mem_wdata = clr_busy_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem[rd_idx_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // same-column write in the read cycle: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_idx_i == rd_idx_i);
    end
  end

  assign rd_data_o  = fwd_q ? fwd_data_q : rdata_q;
  assign clr_busy_o = clr_busy_q;

  `BB3_ASSERT_IMPLY(a_no_read_in_clear, clk_i, rst_ni, clr_busy_q, !rd_en_i, "read during clear sweep")
  `BB3_ASSERT_NEXT(a_bypass_data, clk_i, rst_ni, rd_en_i && wr_en_i && (wr_idx_i == rd_idx_i), rd_data_o == $past(wr_data_i), "bypass lost same-column write")
  `BB3_ASSERT_IMPLY(a_clear_full, clk_i, rst_ni, $fell(clr_busy_q), $past(clr_addr_q) == AW'(Depth - 1), "clear sweep ended early")

endmodule

### src/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 window columns and the nine-pixel sum.
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bb3_pkg::PIX_W-1:0]   px_i,
  input  bb3_pkg::line_t              line_i,
  output logic [bb3_pkg::SUM_W-1:0]   sum_o
);
  import bb3_pkg::*;

  // 0..2: column x-2 (top, mid, bottom); 3..5: column x-1
  logic [PIX_W-1:0] win_q [6];
  logic [SUM_W-1:0] acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (step_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= line_i.upper;
      win_q[4] <= line_i.middle;
      win_q[5] <= px_i;
    end
  end

  always_comb begin
    acc = SUM_W'(px_i) + SUM_W'(line_i.upper) + SUM_W'(line_i.middle);
    for (int i = 0; i < 6; i++) begin
      acc = acc + SUM_W'(win_q[i]);
    end
  end

  assign sum_o = acc;

endmodule

### src/bb3_div9_out.sv
// ----------------------------------------------------------------------------
// bb3_div9_out
// Sum register, divide by nine via reciprocal multiply, result register.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_stream_macros.svh"

module bb3_div9_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bb3_pkg::SUM_W-1:0] sum_i,
  input  bb3_pkg::pos_info_t        info_i,
  bb3_res_if.source                 res_out
);
  import bb3_pkg::*;

  logic                     s2_v_q;
  logic [SUM_W-1:0]         s2_sum_q;
  pos_info_t                s2_info_q;
  logic                     s2_go;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic                     out_v_q;
  res_t                     out_res_q;

  assign s2_go      = s2_v_q && (!out_v_q || res_out.ready);
  assign in_ready_o = !s2_v_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s2_v_q <= in_valid_i;
    end
  end

  // border centers carry a zero sum
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s2_sum_q  <= info_i.interior ? sum_i : '0;
      s2_info_q <= info_i;
    end
  end

  assign prod = {{RECIP_W{1'b0}}, s2_sum_q} * {{SUM_W{1'b0}}, DIV9_RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_go) begin
      out_v_q <= 1'b1;
    end else if (res_out.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_res_q.out_row    <= s2_info_q.row;
      out_res_q.out_col    <= s2_info_q.col;
      out_res_q.blurred    <= prod[DIV9_SHIFT+PIX_W-1:DIV9_SHIFT];
      out_res_q.frame_last <= s2_info_q.last;
    end
  end

  assign res_out.valid = out_v_q;
  assign res_out.data  = out_res_q;

  `BB3_ASSERT_IMPLY(a_top_row_zero, clk_i, rst_ni, out_v_q && (out_res_q.blurred != '0), out_res_q.out_row != '0, "nonzero result on top border row")

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream testbench
// Drives raster pixel streams through the 3x3 box blur under several frame
// sizes, predicts each windowed result in a scoreboard and checks every
// result transfer against it, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bb3_pkg::*;

  localparam int LINE_DEPTH   = 2048;    // line store depth, matches MAX_WIDTH
  localparam int CLK_PERIOD   = 8;
  localparam int PIPE_CYCLES  = 8;       // drain margin after the last due result
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 400;

  // pixel value mixes for the random streams
  typedef enum int {
    PIX_ANY,
    PIX_BRIGHT,
    PIX_DARK,
    PIX_EXTREME
  } pix_mix_e;

  // Scoreboard: own copy of line stores, window and raster position.
  class blur_scoreboard;
    logic [PIX_W-1:0] upper_line  [LINE_DEPTH];
    logic [PIX_W-1:0] middle_line [LINE_DEPTH];
    logic [PIX_W-1:0] taps [6];     // 0..2 column x-2, 3..5 column x-1
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    res_t             due_results [$];
    int               errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (taps[i]) taps[i] = '0;
      col        = 0;
      row        = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function void note_pixel(pix_t item);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      int unsigned      y;
      int unsigned      idx;
      int unsigned      sum;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      res_t             r;
      w = (width_reg < MIN_DIM) ? MIN_DIM :
          ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
      h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
      if (item.frame_start) begin
        col = 0;
        row = 0;
      end
      x   = col;
      y   = row;
      idx = x % LINE_DEPTH;
      up  = upper_line[idx];
      mid = middle_line[idx];
      if (y >= 1 && x >= 1) begin
        r.out_row    = ROW_W'(y - 1);
        r.out_col    = COL_W'(x - 1);
        r.blurred    = '0;
        if (y >= 2 && x >= 2) begin
          sum = up + mid + item.pixel;
          foreach (taps[i]) sum += taps[i];
          r.blurred = PIX_W'(sum / 9);
        end
        r.frame_last = (y == h - 1) && (x == w - 1);
        due_results.push_back(r);
      end
      taps[0] = taps[3];
      taps[1] = taps[4];
      taps[2] = taps[5];
      taps[3] = up;
      taps[4] = mid;
      taps[5] = item.pixel;
      upper_line[idx]  = mid;
      middle_line[idx] = item.pixel;
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: expected none, actual row %0d col %0d val %0d",
                 $time, got.out_row, got.out_col, got.blurred);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.out_row !== want.out_row) begin
        $display("%0t: out_row mismatch: expected %0d, actual %0d",
                 $time, want.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== want.out_col) begin
        $display("%0t: out_col mismatch: expected %0d, actual %0d",
                 $time, want.out_col, got.out_col);
        errors++;
      end
      if (got.blurred !== want.blurred) begin
        $display("%0t: blurred mismatch at (%0d,%0d): expected %0d, actual %0d",
                 $time, want.out_row, want.out_col, want.blurred, got.blurred);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last mismatch at (%0d,%0d): expected %0b, actual %0b",
                 $time, want.out_row, want.out_col, want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 steady_flow;   // suppresses gaps and stalls on both sides
  int                   cycle_count;
  blur_scoreboard       sb;

  bb3_pix_if pix_if ();
  bb3_res_if res_if ();

  box_blur_3x3_stream #(
    .MAX_WIDTH (LINE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_if),
    .res_out    (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side: ready is dropped at random with a chance of 13 in 100 unless the
  // flow is held steady.
  always @(posedge clk_i) begin
    res_if.ready <= steady_flow || ($urandom_range(99) >= 13);
  end

  // Every result transfer is checked against the oldest prediction.
  // Values are read at the edge, before any update from that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.data);
  end

  function automatic logic [PIX_W-1:0] pick_pixel(input pix_mix_e mix);
    case (mix)
      PIX_BRIGHT:  return PIX_W'($urandom_range(240, 255));
      PIX_DARK:    return PIX_W'($urandom_range(0, 15));
      PIX_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One pixel transfer. Optional random gap first; valid stays high on
  // return so back-to-back pixels keep streaming without a bubble.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic mark);
    pix_t item;
    item.pixel       = px;
    item.frame_start = mark;
    while (!steady_flow && $urandom_range(99) < 13) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= item;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    sb.note_pixel(item);
  endtask

  // Stop sending, wait for every due result, then let the pipe empty out
  // (pixels on a border row/column produce nothing but are still in flight).
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Mostly well-formed raster: a frame mark at the frame origin (sometimes
  // left off so the position wraps on its own), plus noise_pct early marks.
  task automatic run_stream(input int n_items, input pix_mix_e mix, input int noise_pct);
    logic mark;
    for (int k = 0; k < n_items; k++) begin
      if (sb.col == 0 && sb.row == 0) mark = ($urandom_range(9) != 0);
      else mark = ($urandom_range(99) < noise_pct);
      send_pixel(pick_pixel(mix), mark);
    end
  endtask

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          phase;
    int          n;
    int          random_sent;
    logic [11:0] w;
    logic [11:0] h;
    sb           = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_IMAGE_WIDTH;
    cfg_data_i   = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    res_if.ready = 1'b0;
    steady_flow  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // Width 0 and height 2 both clamp up to the 3x3 minimum frame.
    configure(12'd0, 12'd2);
    // All-white frame: one interior centre, sum 2295 -> 255, flagged last.
    send_pixel(8'hFF, 1'b1);
    repeat (8) send_pixel(8'hFF, 1'b0);
    // Black frame with no mark: position wraps by itself, window still holds
    // white from the previous frame.
    repeat (9) send_pixel(8'h00, 1'b0);
    // Early mark: restart at origin mid-frame without clearing line stores.
    send_pixel(8'd128, 1'b1);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd7, 1'b0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd3, 1'b0);
    drain_results();

    // ---- random small frames ----
    // Phases do not force a mark on their first pixel, so a size change often
    // lands mid-frame and any position past the new size wraps.
    // Phase 0 pauses the sender halfway until all results are in;
    // phase 2 runs with no gaps and no stalls at all.
    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      n = $urandom_range(40, 110);
      w = ($urandom_range(5) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 12));
      h = ($urandom_range(5) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8));
      configure(w, h);
      steady_flow <= (phase == 2);
      if (phase == 0) begin
        run_stream(n / 2, PIX_ANY, 3);
        drain_results();
        run_stream(n - n / 2, PIX_ANY, 3);
      end else begin
        run_stream(n, pix_mix_e'($urandom_range(3)), 3);
      end
      drain_results();
      random_sent += n;
      phase++;
    end
    steady_flow <= 1'b0;

    // ---- wide rows ----
    // Register at its top value clamps to MAX_WIDTH; the short stream stays on
    // the first row, so nothing is due.
    configure(12'd4095, 12'd0);
    send_pixel(pick_pixel(PIX_ANY), 1'b1);
    run_stream(60, PIX_ANY, 0);
    drain_results();
    // Narrow the rows mid-row: the column is past the new width and wraps.
    configure(12'd6, 12'd0);
    run_stream(30, PIX_ANY, 0);
    drain_results();

    // ---- tall frame ----
    // Narrowest rows (width 1 clamps to 3) with the height at its top value.
    configure(12'd1, 12'd4095);
    send_pixel(pick_pixel(PIX_ANY), 1'b1);
    run_stream(90, PIX_ANY, 0);
    drain_results();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### box_blur_3x3_stream.f
+incdir+src
src/bb3_pkg.sv
src/bb3_if.sv
src/bb3_line_store.sv
src/bb3_window.sv
src/bb3_div9_out.sv
src/box_blur_3x3_stream.sv
tb/sv/tb_top.sv
